// ----- design/msll_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msll_pkg
// Shared types and constants of the masked sigmoid log likelihood core.
// ----------------------------------------------------------------------------
package msll_pkg;

	localparam logic [2:0] REG_CENTER_FIRST   = 3'd0;
	localparam logic [2:0] REG_CENTER_SECOND  = 3'd1;
	localparam logic [2:0] REG_INVERSE_SLOPE  = 3'd2;
	localparam logic [2:0] REG_SEQUENCE_SEL   = 3'd3;
	localparam logic [2:0] REG_MASK_THRESHOLD = 3'd4;

	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [31:0] LN2_Q32   = 32'd2977044472;
	localparam logic [47:0] SUM_MIN   = 48'h8000_0000_0000;

	typedef struct packed {
		logic       load;
		logic       prep;
		logic       scale;
		logic       log2e;
		logic       exp_step;
		logic       eres;
		logic       log_step;
		logic       ln;
		logic       acc;
		logic       emit;
		logic [3:0] step;
	} cmd_t;

	typedef struct packed {
		logic incl;
		logic last;
		logic out_busy;
	} sts_t;

	// 2^(-2^-(j+1)) in Q0.30
	function automatic logic [29:0] exp_tab(input logic [3:0] j);
		logic [29:0] v;
		unique case (j)
			4'd0:    v = 30'd759250125;
			4'd1:    v = 30'd902905651;
			4'd2:    v = 30'd984625594;
			4'd3:    v = 30'd1028218693;
			4'd4:    v = 30'd1050733751;
			4'd5:    v = 30'd1062175491;
			4'd6:    v = 30'd1067942999;
			4'd7:    v = 30'd1070838486;
			4'd8:    v = 30'd1072289173;
			4'd9:    v = 30'd1073015253;
			4'd10:   v = 30'd1073378477;
			4'd11:   v = 30'd1073560135;
			4'd12:   v = 30'd1073650976;
			4'd13:   v = 30'd1073696399;
			4'd14:   v = 30'd1073719111;
			4'd15:   v = 30'd1073730468;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- design/msll_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msll channel interfaces
// Voxel input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface msll_vox_if;
	logic        valid;
	logic        ready;
	logic [15:0] model_value;
	logic        label_is_one;
	logic [15:0] mask_value;
	logic [9:0]  slice_index;
	logic        last_voxel;
	modport source (output valid, model_value, label_is_one, mask_value, slice_index,
		last_voxel, input ready);
	modport sink (input valid, model_value, label_is_one, mask_value, slice_index,
		last_voxel, output ready);
endinterface

interface msll_res_if;
	logic        valid;
	logic        ready;
	logic [47:0] log_sum;
	logic [24:0] point_count;
	logic        sum_saturated;
	modport source (output valid, log_sum, point_count, sum_saturated, input ready);
	modport sink (input valid, log_sum, point_count, sum_saturated, output ready);
endinterface

interface msll_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [23:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- design/masked_sigmoid_log_likelihood_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_sigmoid_log_likelihood_core
// Masked sigmoid log likelihood accumulator over a voxel stream.
// ----------------------------------------------------------------------------
// one voxel at a time: a skipped voxel passes load, prep, scale and log2e to done;
// a counted one adds 16 exp table steps and 16 log2 squaring steps, one multiplier each
// result is registered as the last voxel finishes; a held result stalls only
// a following last voxel
// async reset restores config defaults and clears sum, count and flag
module masked_sigmoid_log_likelihood_core #(
	parameter int SLICE_STRIDE = 6,
	parameter int COUNT_WIDTH  = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	msll_vox_if.sink  vox,
	msll_res_if.source res,
	msll_cfg_if.sink  cfg
);

	msll_pkg::cmd_t cmd;
	msll_pkg::sts_t sts;
	logic           in_ready;

	msll_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vox.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	msll_dp #(
		.SLICE_STRIDE (SLICE_STRIDE),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.vox    (vox),
		.res    (res),
		.cfg    (cfg)
	);

	assign vox.ready = in_ready;

endmodule

// ----- design/msll_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msll_ctrl
// Sequencer: steps one voxel through the datapath phases.
// ----------------------------------------------------------------------------
module msll_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  msll_pkg::sts_t  sts,
	output msll_pkg::cmd_t  cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_PREP  = 4'd1;
	localparam logic [3:0] ST_SCALE = 4'd2;
	localparam logic [3:0] ST_LOG2E = 4'd3;
	localparam logic [3:0] ST_EXP   = 4'd4;
	localparam logic [3:0] ST_ERES  = 4'd5;
	localparam logic [3:0] ST_LOG   = 4'd6;
	localparam logic [3:0] ST_LN    = 4'd7;
	localparam logic [3:0] ST_ACC   = 4'd8;
	localparam logic [3:0] ST_DONE  = 4'd9;

	logic [3:0] state_q, state_d;
	logic [3:0] cnt_q, cnt_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.step = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_LOG2E;
			end
			ST_LOG2E: begin
				cmd.log2e = sts.incl;
				cnt_d     = '0;
				state_d   = sts.incl ? ST_EXP : ST_DONE;
			end
			ST_EXP: begin
				cmd.exp_step = 1'b1;
				cnt_d        = cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					state_d = ST_ERES;
				end
			end
			ST_ERES: begin
				cmd.eres = 1'b1;
				cnt_d    = '0;
				state_d  = ST_LOG;
			end
			ST_LOG: begin
				cmd.log_step = 1'b1;
				cnt_d        = cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					state_d = ST_LN;
				end
			end
			ST_LN: begin
				cmd.ln  = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				// a last beat waits for the result register to drain
				if (!sts.last) begin
					state_d = ST_IDLE;
				end else if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// ----- design/msll_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msll_dp
// Datapath: config registers, sigmoid via exp table, log2 by squaring,
// saturating accumulator and result register.
// ----------------------------------------------------------------------------
module msll_dp #(
	parameter int SLICE_STRIDE = 6,
	parameter int COUNT_WIDTH  = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  msll_pkg::cmd_t  cmd,
	output msll_pkg::sts_t  sts,
	msll_vox_if.sink        vox,
	msll_res_if.source      res,
	msll_cfg_if.sink        cfg
);

	localparam int          RECIP_SH = 20;
	localparam logic [20:0] RECIP    = 21'((1 << RECIP_SH) / SLICE_STRIDE);
	localparam logic [16:0] STRIDE   = 17'(SLICE_STRIDE);

	logic [15:0] center_first_q, center_second_q, mask_threshold_q;
	logic [23:0] inverse_slope_q;
	logic        sequence_select_q;

	logic [15:0] model_q, mask_q;
	logic [9:0]  slice_q;
	logic        label_q, last_q;

	logic        gt_q, lt_q, incl_q;
	logic [31:0] sq_q;
	logic [9:0]  quo_q;
	logic [23:0] x_q;
	logic [24:0] y_q;
	logic [30:0] r_q;
	logic [30:0] m_q;
	logic [4:0]  k_q;
	logic        pz_q;
	logic [15:0] frac_q;
	logic [20:0] term_q;

	logic signed [47:0] sum_q;
	logic [COUNT_WIDTH:0] cnt_q;
	logic        sat_q;

	logic        ov_q;
	logic [47:0] o_sum_q;
	logic [24:0] o_cnt_q;
	logic        o_sat_q;

	assign cfg.ready = 1'b1;

	// prep
	logic [15:0] center, ad;
	logic [30:0] quo_prod;
	always_comb begin
		center   = sequence_select_q ? center_second_q : center_first_q;
		ad       = (model_q >= center) ? (model_q - center) : (center - model_q);
		quo_prod = 31'(slice_q) * 31'(RECIP);
	end

	// scale: remainder lands in [0, 2*stride)
	logic [16:0] rem;
	logic [55:0] x_prod;
	always_comb begin
		rem    = 17'(slice_q) - 17'(quo_q) * STRIDE;
		x_prod = 56'(sq_q) * 56'(inverse_slope_q);
	end

	logic [54:0] y_prod;
	assign y_prod = 55'(x_q) * 55'(msll_pkg::LOG2E_Q30);

	// exp step, msb of the fraction first
	logic [61:0] e_prod;
	logic [3:0]  bit_idx;
	always_comb begin
		bit_idx = 4'd15 - cmd.step;
		e_prod  = 62'(r_q) * 62'(msll_pkg::exp_tab(cmd.step)) + 62'(1 << 29);
	end

	// exp result, probability, leading one
	logic [8:0]  n;
	logic [31:0] e_sum;
	logic [16:0] e, h;
	logic [17:0] pa, p;
	logic [4:0]  k;
	always_comb begin
		n     = y_q[24:16];
		e_sum = 32'(r_q) + (32'd1 << (5'd13 + n[4:0]));
		e     = (n >= 9'd17) ? 17'd0 : 17'(e_sum >> (5'd14 + n[4:0]));
		h     = 17'(18'd65536 - 18'(e));
		if (gt_q) begin
			pa = 18'd65536 + 18'(h);
		end else if (lt_q) begin
			pa = 18'd65536 - 18'(h);
		end else begin
			pa = 18'd65536;
		end
		p = label_q ? pa : (18'd131072 - pa);
		k = '0;
		for (int i = 0; i < 18; i++) begin
			if (p[i]) begin
				k = 5'(i);
			end
		end
	end

	logic [61:0] m_sq;
	logic [31:0] m_s;
	always_comb begin
		m_sq = 62'(m_q) * 62'(m_q);
		m_s  = m_sq[61:30];
	end

	logic [20:0] mag2;
	logic [52:0] ln_prod;
	always_comb begin
		mag2    = pz_q ? 21'(18 << 16) : ((21'(5'd17 - k_q) << 16) - 21'(frac_q));
		ln_prod = 53'(mag2) * 53'(msll_pkg::LN2_Q32) + 53'(64'd1 << 31);
	end

	logic signed [48:0] diff;
	assign diff = 49'(sum_q) - $signed({28'd0, term_q});

	logic [33:0] cnt_ext;
	assign cnt_ext = 34'(cnt_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			model_q <= vox.model_value;
			label_q <= vox.label_is_one;
			mask_q  <= vox.mask_value;
			slice_q <= vox.slice_index;
			last_q  <= vox.last_voxel;
		end
		if (cmd.prep) begin
			sq_q  <= 32'(ad) * 32'(ad);
			gt_q  <= model_q > center;
			lt_q  <= model_q < center;
			quo_q <= quo_prod[29:20];
		end
		if (cmd.scale) begin
			x_q    <= x_prod[55:32];
			incl_q <= ((rem == 17'd0) || (rem == STRIDE)) && (mask_q > mask_threshold_q);
		end
		if (cmd.log2e) begin
			y_q <= y_prod[54:30];
			r_q <= 31'd1 << 30;
		end
		if (cmd.exp_step && y_q[bit_idx]) begin
			r_q <= e_prod[60:30];
		end
		if (cmd.eres) begin
			m_q    <= 31'(p) << (5'd30 - k);
			k_q    <= k;
			pz_q   <= (p == 18'd0);
			frac_q <= '0;
		end
		if (cmd.log_step) begin
			if (m_s[31]) begin
				m_q    <= m_s[31:1];
				frac_q <= {frac_q[14:0], 1'b1};
			end else begin
				m_q    <= m_s[30:0];
				frac_q <= {frac_q[14:0], 1'b0};
			end
		end
		if (cmd.ln) begin
			term_q <= ln_prod[52:32];
		end
		if (cmd.emit) begin
			o_sum_q <= sum_q;
			o_cnt_q <= cnt_ext[24:0];
			o_sat_q <= sat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_first_q    <= 16'd32768;
			center_second_q   <= 16'd16384;
			inverse_slope_q   <= 24'd65536;
			sequence_select_q <= 1'b0;
			mask_threshold_q  <= 16'd655;
			sum_q             <= '0;
			cnt_q             <= '0;
			sat_q             <= 1'b0;
			ov_q              <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					msll_pkg::REG_CENTER_FIRST:   center_first_q    <= cfg.data[15:0];
					msll_pkg::REG_CENTER_SECOND:  center_second_q   <= cfg.data[15:0];
					msll_pkg::REG_INVERSE_SLOPE:  inverse_slope_q   <= cfg.data;
					msll_pkg::REG_SEQUENCE_SEL:   sequence_select_q <= cfg.data[0];
					msll_pkg::REG_MASK_THRESHOLD: mask_threshold_q  <= cfg.data[15:0];
					default: ;
				endcase
			end
			if (cmd.acc) begin
				if (diff < -$signed(49'(msll_pkg::SUM_MIN))) begin
					sum_q <= $signed(msll_pkg::SUM_MIN);
					sat_q <= 1'b1;
				end else begin
					sum_q <= diff[47:0];
				end
				if (!cnt_q[COUNT_WIDTH]) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.emit) begin
				sum_q <= '0;
				cnt_q <= '0;
				sat_q <= 1'b0;
				ov_q  <= 1'b1;
			end else if (res.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign res.valid         = ov_q;
	assign res.log_sum       = o_sum_q;
	assign res.point_count   = o_cnt_q;
	assign res.sum_saturated = o_sat_q;

	assign sts.incl     = incl_q;
	assign sts.last     = last_q;
	assign sts.out_busy = ov_q & ~res.ready;

endmodule

// ----- design/msll_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msll_checker
// Port level checks of the masked sigmoid log likelihood core.
// ----------------------------------------------------------------------------
module msll_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        vox_valid,
	input logic        vox_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [47:0] log_sum,
	input logic        sum_saturated
);

	// a stalled result beat stays up
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped while stalled");

	// one voxel at a time: no accept right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		vox_valid && vox_ready |=> !vox_ready)
		else $error("voxel taken while busy");

	// a saturated sum is pinned at the lower limit
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && sum_saturated |-> log_sum == 48'h8000_0000_0000)
		else $error("saturated sum off its limit");

	// terms never add, so a sum is never positive
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (log_sum[47] || log_sum == 48'd0))
		else $error("positive log sum");

endmodule

bind masked_sigmoid_log_likelihood_core msll_checker u_msll_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.vox_valid     (vox.valid),
	.vox_ready     (vox.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.log_sum       (res.log_sum),
	.sum_saturated (res.sum_saturated)
);
